// ----- rtl/tlpj_pkg.sv -----
// Shared types, constants and a helper function of the two-link planar Jacobian unit.
package tlpj_pkg;

  localparam int unsigned ANG_W   = 16;   // binary angle width
  localparam int unsigned LEN_W   = 16;   // unsigned Q4.12 link length
  localparam int unsigned ROT_W   = 32;   // CORDIC x, y, z word width
  localparam int unsigned PROD_W  = 49;   // 17 x 32 signed product
  localparam int unsigned SUM_W   = 50;   // sum of two products
  localparam int unsigned FRAC_SH = 30;   // Q.42 down to Q8.12
  localparam int unsigned OUT_W   = 20;   // signed Q8.12 result
  localparam int unsigned STAGES  = 16;   // CORDIC micro-rotations
  localparam int unsigned CFG_W   = 1;    // register index width

  // Register indexes of the configuration port
  localparam logic [CFG_W-1:0] CFG_LINK_ONE = 1'b0;
  localparam logic [CFG_W-1:0] CFG_LINK_TWO = 1'b1;

  // Gain-compensated 1.0 in Q2.30
  localparam logic signed [ROT_W-1:0] CORDIC_X0 = 32'sd652032874;

  // A quarter turn in binary angle units
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 16'sd16384;

  // atan(2^-i) with a full circle equal to 2^32
  localparam logic signed [ROT_W-1:0] ARC_TABLE [STAGES] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335086,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
  };

  // Rotation state carried from cell to cell
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
    logic                    flip;
  } rot_t;

  // One result item
  typedef struct packed {
    logic signed [OUT_W-1:0] r0c0;
    logic signed [OUT_W-1:0] r0c1;
    logic signed [OUT_W-1:0] r1c0;
    logic signed [OUT_W-1:0] r1c1;
  } res_t;

  // Fold an angle into the right half-plane and seed the rotator
  function automatic rot_t prerot(input logic signed [ANG_W-1:0] ang);
    rot_t r;
    logic big;
    big    = (ang > ANG_QUARTER) || (ang < -ANG_QUARTER);
    r.x    = CORDIC_X0;
    r.y    = '0;
    r.flip = big;
    // moving z by half a turn only toggles its top bit
    r.z    = big ? {~ang[ANG_W-1], ang[ANG_W-2:0], 16'h0000} : {ang, 16'h0000};
    return r;
  endfunction

endpackage

// ----- rtl/tlpj_cordic_cell.sv -----
// One rotation-mode CORDIC cell: a single micro-rotation and its register.
module tlpj_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic             clk,
  input  logic             en,
  input  tlpj_pkg::rot_t   rot_i,
  output tlpj_pkg::rot_t   rot_o
);

  logic signed [tlpj_pkg::ROT_W-1:0] x;
  logic signed [tlpj_pkg::ROT_W-1:0] y;
  logic signed [tlpj_pkg::ROT_W-1:0] z;
  logic signed [tlpj_pkg::ROT_W-1:0] xs;
  logic signed [tlpj_pkg::ROT_W-1:0] ys;
  tlpj_pkg::rot_t rot_nxt;
  tlpj_pkg::rot_t rot_r;

  assign x  = rot_i.x;
  assign y  = rot_i.y;
  assign z  = rot_i.z;
  assign xs = x >>> STAGE;
  assign ys = y >>> STAGE;

  // Rotate toward zero residual angle
  always_comb begin
    rot_nxt.flip = rot_i.flip;
    if (!z[tlpj_pkg::ROT_W-1]) begin
      rot_nxt.x = x - ys;
      rot_nxt.y = y + xs;
      rot_nxt.z = z - tlpj_pkg::ARC_TABLE[STAGE];
    end else begin
      rot_nxt.x = x + ys;
      rot_nxt.y = y - xs;
      rot_nxt.z = z + tlpj_pkg::ARC_TABLE[STAGE];
    end
  end

  // Advance when the pipeline moves
  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
    end
  end

  assign rot_o = rot_r;

endmodule

// ----- rtl/tlpj_mac.sv -----
// Sign fix, length products and row sums, three register stages.
module tlpj_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  tlpj_pkg::rot_t                rot_one_i,
  input  tlpj_pkg::rot_t                rot_sum_i,
  input  logic [tlpj_pkg::LEN_W-1:0]    len_one,
  input  logic [tlpj_pkg::LEN_W-1:0]    len_two,
  output logic                          vld_o,
  output tlpj_pkg::res_t                res_o
);

  logic signed [tlpj_pkg::ROT_W-1:0]  c1_r, s1_r, cs_r, ss_r;
  logic signed [tlpj_pkg::PROD_W-1:0] p_l1c1_r, p_l2cs_r, p_l1s1_r, p_l2ss_r;
  logic signed [tlpj_pkg::PROD_W-1:0] p_l1c1_nxt, p_l2cs_nxt, p_l1s1_nxt, p_l2ss_nxt;
  logic signed [tlpj_pkg::LEN_W:0]    l1s, l2s;
  logic signed [tlpj_pkg::SUM_W-1:0]  sum_c_nxt, sum_s_nxt;
  tlpj_pkg::res_t                     res_nxt;
  tlpj_pkg::res_t                     res_r;
  logic [2:0]                         vld_r;

  assign l1s = $signed({1'b0, len_one});
  assign l2s = $signed({1'b0, len_two});

  assign p_l1c1_nxt = l1s * c1_r;
  assign p_l2cs_nxt = l2s * cs_r;
  assign p_l1s1_nxt = l1s * s1_r;
  assign p_l2ss_nxt = l2s * ss_r;

  assign sum_c_nxt = {p_l1c1_r[tlpj_pkg::PROD_W-1], p_l1c1_r}
                   + {p_l2cs_r[tlpj_pkg::PROD_W-1], p_l2cs_r};
  assign sum_s_nxt = {p_l1s1_r[tlpj_pkg::PROD_W-1], p_l1s1_r}
                   + {p_l2ss_r[tlpj_pkg::PROD_W-1], p_l2ss_r};

  // Floor to Q8.12 by dropping 30 fraction bits
  always_comb begin
    res_nxt.r0c0 = sum_c_nxt[tlpj_pkg::SUM_W-1:tlpj_pkg::FRAC_SH];
    res_nxt.r1c0 = sum_s_nxt[tlpj_pkg::SUM_W-1:tlpj_pkg::FRAC_SH];
    res_nxt.r0c1 = {p_l2cs_r[tlpj_pkg::PROD_W-1],
                    p_l2cs_r[tlpj_pkg::PROD_W-1:tlpj_pkg::FRAC_SH]};
    res_nxt.r1c1 = {p_l2ss_r[tlpj_pkg::PROD_W-1],
                    p_l2ss_r[tlpj_pkg::PROD_W-1:tlpj_pkg::FRAC_SH]};
  end

  // Payload stages: undo the half-turn fold, multiply, then sum
  always_ff @(posedge clk) begin
    if (en) begin
      c1_r     <= rot_one_i.flip ? -rot_one_i.x : rot_one_i.x;
      s1_r     <= rot_one_i.flip ? -rot_one_i.y : rot_one_i.y;
      cs_r     <= rot_sum_i.flip ? -rot_sum_i.x : rot_sum_i.x;
      ss_r     <= rot_sum_i.flip ? -rot_sum_i.y : rot_sum_i.y;
      p_l1c1_r <= p_l1c1_nxt;
      p_l2cs_r <= p_l2cs_nxt;
      p_l1s1_r <= p_l1s1_nxt;
      p_l2ss_r <= p_l2ss_nxt;
      res_r    <= res_nxt;
    end
  end

  // Track occupancy of the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  assign vld_o = vld_r[2];
  assign res_o = res_r;

endmodule

// ----- rtl/tlpj_out_skid.sv -----
// Output register with a one-entry skid stage; ready toward the pipeline is registered.
module tlpj_out_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  tlpj_pkg::res_t res_i,
  output logic           en,
  input  logic           out_ready,
  output logic           out_valid,
  output tlpj_pkg::res_t res_o
);

  logic           out_valid_r;
  logic           skid_full_r;
  tlpj_pkg::res_t out_r;
  tlpj_pkg::res_t skid_r;
  logic           take;

  assign en   = !skid_full_r;
  assign take = vld_i && en;

  // Control: refill the output from skid first, park an item when stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_full_r) begin
        out_valid_r <= 1'b1;
        skid_full_r <= 1'b0;
      end else begin
        out_valid_r <= take;
      end
    end else if (take) begin
      skid_full_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_full_r) begin
        out_r <= skid_r;
      end else if (take) begin
        out_r <= res_i;
      end
    end else if (take) begin
      skid_r <= res_i;
    end
  end

  assign out_valid = out_valid_r;
  assign res_o     = out_r;

endmodule

// ----- rtl/two_link_planar_jacobian_unit.sv -----
// Two-link planar arm matrix: two CORDIC cell chains, length products and row sums.
// Takes one pair of joint angles per cycle and returns l1*cos(a1)+l2*cos(a1+a2),
// l2*cos(a1+a2), l1*sin(a1)+l2*sin(a1+a2) and l2*sin(a1+a2) in signed Q8.12, floored.
// From input transfer to output valid: one fold register, a chain of 16 CORDIC cells
// (one micro-rotation each, two chains side by side for a1 and a1+a2), three
// multiply-and-sum stages and the output register. The whole pipeline holds while the
// output skid entry is full, and in_ready comes straight from that entry. The user must
// write link lengths on the cfg port only while idle; the block does not enforce it.
module two_link_planar_jacobian_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tlpj_pkg::CFG_W-1:0]          cfg_index,
  input  logic [tlpj_pkg::LEN_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tlpj_pkg::ANG_W-1:0]   in_joint_angle_one,
  input  logic signed [tlpj_pkg::ANG_W-1:0]   in_joint_angle_two,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tlpj_pkg::OUT_W-1:0]   out_row0_col0,
  output logic signed [tlpj_pkg::OUT_W-1:0]   out_row0_col1,
  output logic signed [tlpj_pkg::OUT_W-1:0]   out_row1_col0,
  output logic signed [tlpj_pkg::OUT_W-1:0]   out_row1_col1
);

  logic                              en;
  logic [tlpj_pkg::LEN_W-1:0]        len_one_r;
  logic [tlpj_pkg::LEN_W-1:0]        len_two_r;
  logic signed [tlpj_pkg::ANG_W-1:0] ang_sum;
  logic [tlpj_pkg::STAGES:0]         vld_r;
  tlpj_pkg::rot_t                    rot_one [tlpj_pkg::STAGES+1];
  tlpj_pkg::rot_t                    rot_sum [tlpj_pkg::STAGES+1];
  tlpj_pkg::rot_t                    rot_one_r;
  tlpj_pkg::rot_t                    rot_sum_r;
  logic                              mac_vld;
  tlpj_pkg::res_t                    mac_res;
  tlpj_pkg::res_t                    res;

  // Hold the link lengths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_one_r <= '0;
      len_two_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tlpj_pkg::CFG_LINK_ONE: len_one_r <= cfg_data;
        tlpj_pkg::CFG_LINK_TWO: len_two_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Angle sum wraps at 16 bits
  assign ang_sum = in_joint_angle_one + in_joint_angle_two;

  // Fold both angles into the right half-plane
  always_ff @(posedge clk) begin
    if (en) begin
      rot_one_r <= tlpj_pkg::prerot(in_joint_angle_one);
      rot_sum_r <= tlpj_pkg::prerot(ang_sum);
    end
  end

  assign rot_one[0] = rot_one_r;
  assign rot_sum[0] = rot_sum_r;

  // Occupancy alongside the fold register and the cell chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[tlpj_pkg::STAGES-1:0], in_valid};
    end
  end

  // Two chains of rotation cells
  for (genvar i = 0; i < tlpj_pkg::STAGES; i++) begin : g_cell
    tlpj_cordic_cell #(.STAGE(i)) u_cell_one (
      .clk   (clk),
      .en    (en),
      .rot_i (rot_one[i]),
      .rot_o (rot_one[i+1])
    );
    tlpj_cordic_cell #(.STAGE(i)) u_cell_sum (
      .clk   (clk),
      .en    (en),
      .rot_i (rot_sum[i]),
      .rot_o (rot_sum[i+1])
    );
  end

  tlpj_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_i     (vld_r[tlpj_pkg::STAGES]),
    .rot_one_i (rot_one[tlpj_pkg::STAGES]),
    .rot_sum_i (rot_sum[tlpj_pkg::STAGES]),
    .len_one   (len_one_r),
    .len_two   (len_two_r),
    .vld_o     (mac_vld),
    .res_o     (mac_res)
  );

  tlpj_out_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (mac_vld),
    .res_i     (mac_res),
    .en        (en),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_o     (res)
  );

  assign in_ready      = en;
  assign out_row0_col0 = res.r0c0;
  assign out_row0_col1 = res.r0c1;
  assign out_row1_col0 = res.r1c0;
  assign out_row1_col1 = res.r1c1;

endmodule

// ----- rtl/tlpj_checker.sv -----
// Port-level checks of the two-link planar Jacobian unit and their bind.
module tlpj_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [tlpj_pkg::ANG_W-1:0]   in_joint_angle_one,
  input logic signed [tlpj_pkg::ANG_W-1:0]   in_joint_angle_two,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [tlpj_pkg::OUT_W-1:0]   out_row0_col0,
  input logic signed [tlpj_pkg::OUT_W-1:0]   out_row0_col1,
  input logic signed [tlpj_pkg::OUT_W-1:0]   out_row1_col0,
  input logic signed [tlpj_pkg::OUT_W-1:0]   out_row1_col1
);

  // A waiting input keeps its angles until transfer
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_joint_angle_one)
      && $stable(in_joint_angle_two))
    else $error("input changed while waiting");

  // A held result keeps its value until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row0_col0)
      && $stable(out_row0_col1) && $stable(out_row1_col0) && $stable(out_row1_col1))
    else $error("result changed while stalled");

  // Input stalls only while a result is waiting at the output
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // Input stalls only after the output side refused a result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  // Input resumes only after the output side took a result
  a_resume_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) |-> $past(out_ready))
    else $error("input resumed without output transfer");

endmodule

bind two_link_planar_jacobian_unit tlpj_checker u_tlpj_checker (.*);

// ----- sim/testbench.sv -----
// Testbench for two_link_planar_jacobian_unit: checks every result against a built-in model.
`timescale 1ns / 100ps

module testbench;

  typedef logic signed [tlpj_pkg::ANG_W-1:0] angle_t;
  typedef logic [tlpj_pkg::LEN_W-1:0]        length_t;

  typedef struct packed {
    logic signed [tlpj_pkg::OUT_W-1:0] r0c0;
    logic signed [tlpj_pkg::OUT_W-1:0] r0c1;
    logic signed [tlpj_pkg::OUT_W-1:0] r1c0;
    logic signed [tlpj_pkg::OUT_W-1:0] r1c1;
  } jacobian_t;

  // Clock, reset and block ports
  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [tlpj_pkg::CFG_W-1:0]        cfg_index = tlpj_pkg::CFG_LINK_ONE;
  logic [tlpj_pkg::LEN_W-1:0]        cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  angle_t                            in_joint_angle_one = '0;
  angle_t                            in_joint_angle_two = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [tlpj_pkg::OUT_W-1:0] out_row0_col0;
  logic signed [tlpj_pkg::OUT_W-1:0] out_row0_col1;
  logic signed [tlpj_pkg::OUT_W-1:0] out_row1_col0;
  logic signed [tlpj_pkg::OUT_W-1:0] out_row1_col1;

  // Model copy of the link registers
  length_t   link_one_q412 = '0;
  length_t   link_two_q412 = '0;
  jacobian_t jacobian_q [$];

  int mismatch_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  // atan(2^-i) with a full circle of 2^32
  longint atan_turns [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335086, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  two_link_planar_jacobian_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_joint_angle_one (in_joint_angle_one),
    .in_joint_angle_two (in_joint_angle_two),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_row0_col0      (out_row0_col0),
    .out_row0_col1      (out_row0_col1),
    .out_row1_col0      (out_row1_col0),
    .out_row1_col1      (out_row1_col1)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Cosine and sine in Q2.30 by 16 CORDIC micro-rotations
  function automatic void cordic_cos_sin(input angle_t ang, output longint cos_q30,
                                         output longint sin_q30);
    longint z, x, y, nx;
    bit     flip;
    z    = longint'(ang) * 64'sd65536;
    x    = 64'sd652032874;
    y    = 0;
    flip = 1'b0;
    // fold into the right half-plane, undo with a sign change at the end
    if (z > 64'sd1073741824) begin
      z    = z - 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z    = z + 64'sd2147483648;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_turns[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_turns[i];
      end
      x = nx;
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  // Floor a Q.42 sum down to a signed Q8.12 field
  function automatic logic signed [tlpj_pkg::OUT_W-1:0] q42_to_q812(input longint v);
    longint t;
    t = v >>> 30;
    return t[tlpj_pkg::OUT_W-1:0];
  endfunction

  // Arm matrix for one angle pair at the current link lengths
  function automatic jacobian_t jacobian_of(input angle_t a1, input angle_t a2);
    angle_t    ang_sum;
    longint    c1, s1, cs, ss, l1, l2;
    jacobian_t j;
    ang_sum = a1 + a2;
    l1      = longint'(link_one_q412);
    l2      = longint'(link_two_q412);
    cordic_cos_sin(a1, c1, s1);
    cordic_cos_sin(ang_sum, cs, ss);
    j.r0c0 = q42_to_q812(l1 * c1 + l2 * cs);
    j.r0c1 = q42_to_q812(l2 * cs);
    j.r1c0 = q42_to_q812(l1 * s1 + l2 * ss);
    j.r1c1 = q42_to_q812(l2 * ss);
    return j;
  endfunction

  // Print the first few mismatches, count them all
  task automatic report_mismatch(input string msg);
    if (mismatch_count < 30) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string field,
                             input logic signed [tlpj_pkg::OUT_W-1:0] got,
                             input logic signed [tlpj_pkg::OUT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                results_checked, field, got, want));
  endtask

  // Compare each result transfer with the oldest expectation, then pick out_ready
  always @(posedge clk) begin
    jacobian_t want;
    if (rst_n && out_valid && out_ready) begin
      if (jacobian_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = jacobian_q.pop_front();
        check_field("row0_col0", out_row0_col0, want.r0c0);
        check_field("row0_col1", out_row0_col1, want.r0c1);
        check_field("row1_col0", out_row1_col0, want.r1c0);
        check_field("row1_col1", out_row1_col1, want.r1c1);
      end
      results_checked++;
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Send one angle pair; predict at the transfer, then maybe idle
  task automatic send_angles(input angle_t a1, input angle_t a2);
    in_valid           <= 1'b1;
    in_joint_angle_one <= a1;
    in_joint_angle_two <= a2;
    do @(posedge clk); while (!in_ready);
    jacobian_q.insert(jacobian_q.size(), jacobian_of(a1, a2));
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Stop sending and wait for every expected result, with a limit
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (jacobian_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (jacobian_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", jacobian_q.size()));
      jacobian_q.delete();
    end
    repeat (25) @(posedge clk);
  endtask

  // Write both link registers; the block is idle here
  task automatic set_links(input length_t l1, input length_t l2);
    cfg_we    <= 1'b1;
    cfg_index <= tlpj_pkg::CFG_LINK_ONE;
    cfg_data  <= l1;
    @(posedge clk);
    cfg_index <= tlpj_pkg::CFG_LINK_TWO;
    cfg_data  <= l2;
    @(posedge clk);
    cfg_we        <= 1'b0;
    link_one_q412 = l1;
    link_two_q412 = l2;
  endtask

  function automatic length_t pick_length();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return length_t'($urandom);
    endcase
  endfunction

  // Mostly uniform angles, some on the fold boundary and the extremes
  function automatic angle_t pick_angle();
    angle_t notable [6] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh4000, -16'sh4000,
                            16'shffff};
    case ($urandom_range(9))
      0:       return notable[$urandom_range(5)];
      1:       return ($urandom_range(1) ? 16'sh4000 : -16'sh4000) +
                      angle_t'($urandom_range(4)) - 16'sd2;
      default: return angle_t'($urandom);
    endcase
  endfunction

  // Lengths still at reset: every entry must be zero
  task automatic test_reset_lengths();
    send_angles(16'sh0000, 16'sh0000);
    send_angles(16'sh8000, 16'sh7fff);
    send_angles(16'sh1234, -16'sh4321);
    drain_results();
  endtask

  // Fold boundaries, extremes and angle-sum wrap
  task automatic test_angle_extremes();
    set_links(16'h1000, 16'h0800);
    send_angles(16'sh0000, 16'sh0000);
    send_angles(16'sh4000, 16'sh0000);
    send_angles(16'sh4001, 16'sh0000);
    send_angles(-16'sh4000, 16'sh0000);
    send_angles(-16'sh4001, 16'sh0000);
    send_angles(16'sh8000, 16'sh0000);
    send_angles(16'sh7fff, 16'sh7fff);
    send_angles(16'sh7fff, 16'sh0001);
    send_angles(16'sh8000, 16'sh8000);
    send_angles(16'sh2000, 16'sh6000);
    send_angles(16'shffff, 16'sh0001);
    send_angles(16'sh5555, 16'shaaaa);
    drain_results();
  endtask

  // Full-scale and mixed link lengths
  task automatic test_length_extremes();
    set_links(16'hffff, 16'hffff);
    send_angles(16'sh0000, 16'sh0000);
    send_angles(16'sh8000, 16'sh0000);
    send_angles(16'sh4000, 16'sh0000);
    send_angles(-16'sh4000, 16'sh8000);
    drain_results();
    set_links(16'h0000, 16'hffff);
    send_angles(16'sh2000, 16'sh1000);
    drain_results();
    set_links(16'hffff, 16'h0000);
    send_angles(-16'sh6000, 16'sh7fff);
    drain_results();
  endtask

  // Random stream over the handshake idle and stall mixes, new lengths per half phase
  task automatic test_random_stream();
    int idle_mix  [4] = '{0, 65, 0, 26};
    int stall_mix [4] = '{0, 0, 65, 26};
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_mix[p];
      stall_pct = stall_mix[p];
      for (int h = 0; h < 2; h++) begin
        set_links(pick_length(), pick_length());
        repeat (100) send_angles(pick_angle(), pick_angle());
        drain_results();
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_lengths();
    test_angle_extremes();
    test_length_extremes();
    test_random_stream();
    $display("Sent %0d angle pairs, checked %0d results over reset, fixed and random lengths",
             items_sent, results_checked);
    $display("Handshake mixes: free flow, sender gaps, receiver stalls, both");
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
